FILE: sv/mlfq_pkg.sv
// Shared types and constants for the MLFQ priority calculator.
package mlfq_pkg;

    localparam int FRACTION_BITS_DEF = 14;
    localparam int PRIORITY_MAX      = 63;

    localparam int WORD_W   = 32;
    localparam int PROD_W   = 2 * WORD_W;
    localparam int OP_W     = 3;
    localparam int READY_W  = 7;
    localparam int NICE_W   = 6;
    localparam int PRIO_W   = 6;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 104;

    localparam logic [OP_W-1:0] OP_LOAD_UPDATE = 3'd0;
    localparam logic [OP_W-1:0] OP_DECAY       = 3'd1;
    localparam logic [OP_W-1:0] OP_PRIORITY    = 3'd2;
    localparam logic [OP_W-1:0] OP_INCREMENT   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_LOAD   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_CPU    = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_POST
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

FILE: sv/mlfq_div.sv
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
module mlfq_div #(
    parameter int DIV_W = mlfq_pkg::WORD_W + mlfq_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DIV_W-1:0]              i_dividend,
    input  logic [mlfq_pkg::WORD_W-1:0]   i_divisor,
    output logic [DIV_W-1:0]              o_quotient,
    output mlfq_pkg::t_div_status         o_status
);
    import mlfq_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [WORD_W:0]   r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [WORD_W-1:0] r_dsr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [WORD_W:0]   w_shift;
    logic [WORD_W+1:0] w_diff;
    logic              w_ge;

    // Shift in the next dividend bit, then trial-subtract the divisor.
    assign w_shift = {r_rem[WORD_W-1:0], r_quo[DIV_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dsr};
    assign w_ge    = ~w_diff[WORD_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[WORD_W:0] : w_shift;
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_quotient    = r_quo;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

FILE: sv/mlfq_mul.sv
// Shared 32x32 signed multiplier with a registered product.
module mlfq_mul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [mlfq_pkg::WORD_W-1:0]  i_a,
    input  logic signed [mlfq_pkg::WORD_W-1:0]  i_b,
    output logic signed [mlfq_pkg::PROD_W-1:0]  o_prod
);
    import mlfq_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: sv/mlfq_priority_calculator_unit.sv
// Top level of the MLFQ load-average and priority calculator.
//
// Fixed-point helper for a multilevel feedback queue scheduler. Values are
// signed two's complement with FRACTION_BITS fraction bits. Each input
// transaction carries an opcode in tuser and returns exactly one output
// transaction: update the load average from the ready count, decay or
// increment a thread's recent CPU, compute a thread's priority (rounded and
// clamped to 0..PRIORITY_MAX, 0 for the idle thread), or report the load
// average or recent CPU times 100, rounded to nearest. The load average is the
// only state and resets to zero. Sequencing: priority, increment, idle-thread
// decay and unused opcodes go from idle straight to the post state, where the
// result register loads; load update, both reports and a decay whose divisor
// wraps to zero first make one pass through the shared multiplier; decay of a
// non-idle thread first runs the bit-serial divider that forms the decay
// factor, one quotient bit per cycle, followed by the multiplier. The
// sequencer returns to idle as the result loads, so the next transaction is
// accepted in the cycle after the result loads at the earliest: the block takes
// no new transaction before the last result has loaded, and waits longer while
// a waiting result blocks the next one. The input is ready whenever the
// sequencer is idle and out of reset, also while a finished result still
// waits in the output register.
module mlfq_priority_calculator_unit #(
    parameter int FRACTION_BITS = mlfq_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata, low bit up: ready_count[6:0], current_is_idle[7],
    // recent_cpu_in[39:8], nice_value[45:40], zero fill[47:46]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mlfq_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // tuser: op[2:0]
    input  logic [mlfq_pkg::OP_W-1:0]       s_axis_tuser,
    // tdata, low bit up: recent_cpu_out[31:0], priority_out[37:32],
    // load_average_out[69:38], scaled_report[101:70], zero fill[103:102]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mlfq_pkg::M_DATA_W-1:0]   m_axis_tdata
);
    import mlfq_pkg::*;

    localparam int FB    = FRACTION_BITS;
    localparam int DIV_W = WORD_W + FB;

    localparam longint FP_ONE_L = longint'(1) << FB;
    localparam logic signed [WORD_W-1:0] FP_ONE  = WORD_W'(FP_ONE_L);
    localparam logic signed [WORD_W-1:0] C59     = WORD_W'((59 * FP_ONE_L) / 60);
    localparam logic signed [WORD_W-1:0] C1      = WORD_W'(FP_ONE_L / 60);
    localparam logic signed [WORD_W-1:0] HUNDRED = WORD_W'(100);
    localparam logic signed [PROD_W-1:0] HALF    = PROD_W'(FP_ONE_L / 2);
    localparam logic signed [PROD_W-1:0] PMAX_F  =
        PROD_W'(longint'(PRIORITY_MAX) << FB);
    localparam logic signed [PROD_W-1:0] PMAX_I  = PROD_W'(PRIORITY_MAX);

    // Divide by 2^sh, truncating toward zero.
    function automatic logic signed [PROD_W-1:0] shr_trunc(
        input logic signed [PROD_W-1:0] v,
        input int                       sh
    );
        logic signed [PROD_W-1:0] bias;
        bias = v[PROD_W-1] ? ((PROD_W'(1) <<< sh) - PROD_W'(1)) : '0;
        return (v + bias) >>> sh;
    endfunction

    // Round to nearest integer, halves away from zero.
    function automatic logic signed [PROD_W-1:0] round_fx(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [PROD_W-1:0] res;
        if (!v[PROD_W-1]) begin
            res = (v + HALF) >>> FB;
        end else begin
            res = shr_trunc(v - HALF, FB);
        end
        return res;
    endfunction

    // Input fields
    logic [OP_W-1:0] s_op;
    logic            s_idle;
    assign s_op   = s_axis_tuser;
    assign s_idle = s_axis_tdata[7];

    t_state r_state, n_state;

    logic [OP_W-1:0]           r_op;
    logic [READY_W-1:0]        r_ready;
    logic                      r_idle;
    logic signed [WORD_W-1:0]  r_rc;
    logic signed [NICE_W-1:0]  r_nice;
    logic signed [WORD_W-1:0]  r_load, n_load;
    logic signed [WORD_W-1:0]  r_decay;
    logic                      r_m_valid;
    logic [M_DATA_W-1:0]       r_m_data;

    logic w_in_fire;
    logic w_out_free;
    logic w_div_start;
    logic w_mul_en;
    logic w_out_load;

    // Decay divisor terms, taken from the held load average
    logic signed [WORD_W-1:0] w_d2;
    logic signed [WORD_W-1:0] w_den;
    logic                     w_den_zero;
    logic [WORD_W-1:0]        w_d2_mag;
    logic [WORD_W-1:0]        w_den_mag;
    logic                     w_q_neg;
    logic [DIV_W-1:0]         w_quo;
    logic [WORD_W-1:0]        w_q32;
    t_div_status              w_div_stat;

    logic signed [WORD_W-1:0] w_mul_a;
    logic signed [WORD_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0] w_prod;

    assign w_d2       = {r_load[WORD_W-2:0], 1'b0};
    assign w_den      = w_d2 + FP_ONE;
    assign w_den_zero = (w_den == '0);
    assign w_d2_mag   = w_d2[WORD_W-1] ? WORD_W'(-w_d2) : WORD_W'(w_d2);
    assign w_den_mag  = w_den[WORD_W-1] ? WORD_W'(-w_den) : WORD_W'(w_den);
    assign w_q_neg    = w_d2[WORD_W-1] ^ w_den[WORD_W-1];
    assign w_q32      = w_quo[WORD_W-1:0];

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    mlfq_div #(
        .DIV_W(DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({w_d2_mag, {FB{1'b0}}}),
        .i_divisor  (w_den_mag),
        .o_quotient (w_quo),
        .o_status   (w_div_stat)
    );

    // Route operands into the shared multiplier per opcode.
    always_comb begin
        unique case (r_op)
            OP_LOAD_UPDATE: begin
                w_mul_a = C59;
                w_mul_b = r_load;
            end
            OP_DECAY: begin
                w_mul_a = r_decay;
                w_mul_b = r_rc;
            end
            OP_READ_LOAD: begin
                w_mul_a = r_load;
                w_mul_b = HUNDRED;
            end
            default: begin
                w_mul_a = r_rc;
                w_mul_b = HUNDRED;
            end
        endcase
    end

    mlfq_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    priority if (s_op == OP_DECAY && !s_idle && !w_den_zero) begin
                        n_state = ST_DIV;
                    end else if ((s_op == OP_DECAY && !s_idle) ||
                                 s_op == OP_LOAD_UPDATE ||
                                 s_op == OP_READ_LOAD ||
                                 s_op == OP_READ_CPU) begin
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_POST;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_POST;
            end
            ST_POST: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_mul_en      = 1'b0;
        w_out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = i_rst_n;
                w_div_start   = s_axis_tvalid && s_op == OP_DECAY && !s_idle &&
                                !w_den_zero;
            end
            ST_MUL: begin
                w_mul_en = 1'b1;
            end
            ST_POST: begin
                w_out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // Result formation from the held fields and the registered product
    logic signed [PROD_W-1:0] w_prod_q;
    logic signed [PROD_W-1:0] w_nice_ext;
    logic signed [PROD_W-1:0] w_prio_raw;
    logic signed [PROD_W-1:0] w_prio_rnd;
    logic [PRIO_W-1:0]        w_prio_clamp;
    logic [7:0]               w_total;
    logic signed [WORD_W-1:0] w_load_new;
    logic signed [WORD_W-1:0] w_rc_out;
    logic [PRIO_W-1:0]        w_prio;
    logic signed [WORD_W-1:0] w_report;

    assign w_prod_q   = shr_trunc(w_prod, FB);
    assign w_nice_ext = PROD_W'(r_nice);
    assign w_total    = {1'b0, r_ready} + {7'b0, ~r_idle};
    assign w_load_new = WORD_W'(w_prod_q) + C1 * WORD_W'(w_total);
    assign w_prio_raw = PMAX_F - shr_trunc(PROD_W'(r_rc), 2) - (w_nice_ext <<< (FB + 1));
    assign w_prio_rnd = round_fx(w_prio_raw);

    always_comb begin
        priority if (w_prio_rnd[PROD_W-1]) begin
            w_prio_clamp = '0;
        end else if (w_prio_rnd > PMAX_I) begin
            w_prio_clamp = PRIO_W'(PRIORITY_MAX);
        end else begin
            w_prio_clamp = w_prio_rnd[PRIO_W-1:0];
        end
    end

    always_comb begin
        n_load   = r_load;
        w_rc_out = r_rc;
        w_prio   = '0;
        w_report = '0;
        unique case (r_op)
            OP_LOAD_UPDATE: begin
                n_load = w_load_new;
            end
            OP_DECAY: begin
                if (!r_idle) begin
                    w_rc_out = WORD_W'(w_prod_q) + WORD_W'(w_nice_ext <<< FB);
                end
            end
            OP_PRIORITY: begin
                if (!r_idle) begin
                    w_prio = w_prio_clamp;
                end
            end
            OP_INCREMENT: begin
                if (!r_idle) begin
                    w_rc_out = r_rc + FP_ONE;
                end
            end
            OP_READ_LOAD, OP_READ_CPU: begin
                w_report = WORD_W'(round_fx(w_prod));
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_load    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_load    <= n_load;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers: capture the transaction, the decay factor and the result
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op    <= s_op;
            r_ready <= s_axis_tdata[6:0];
            r_idle  <= s_idle;
            r_rc    <= s_axis_tdata[39:8];
            r_nice  <= s_axis_tdata[45:40];
            r_decay <= '0;
        end else if (r_state == ST_DIV && w_div_stat.done) begin
            r_decay <= w_q_neg ? -w_q32 : w_q32;
        end
        if (w_out_load) begin
            r_m_data <= {2'b00, w_report, n_load, w_prio, w_rc_out};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // The divider runs only while the sequencer waits on it.
    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_stat.busy || w_div_stat.done) |-> r_state == ST_DIV)
        else $error("divider active outside the divide state");

    // The load average moves only when a load update completes.
    a_load_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_load != $past(r_load)) |->
        $past(w_out_load && r_op == OP_LOAD_UPDATE))
        else $error("load average changed outside a load update");

    // A result never overwrites one that is still waiting.
    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POST && r_m_valid && !m_axis_tready) |=> r_state == ST_POST)
        else $error("result written over a pending transaction");

    // The idle thread always gets priority zero.
    a_idle_priority_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_op == OP_PRIORITY && r_idle) |=> m_axis_tdata[37:32] == '0)
        else $error("idle thread priority not zero");

endmodule

FILE: bench/mlfq_priority_calculator_unit_tb.sv
// Self-checking testbench for the MLFQ load-average and priority calculator.
`timescale 1ns / 100ps

module mlfq_priority_calculator_unit_tb;
    import mlfq_pkg::*;

    localparam int              FRAC         = FRACTION_BITS_DEF;
    localparam longint          FP_ONE       = longint'(1) << FRAC;
    // Fixed-point weights of the load average: 59/60 and 1/60.
    localparam longint          LOAD_KEEP    = (longint'(59) * FP_ONE * FP_ONE)
                                               / (longint'(60) * FP_ONE);
    localparam longint          LOAD_GAIN    = (FP_ONE * FP_ONE) / (longint'(60) * FP_ONE);
    localparam int unsigned     CPU_SPAN     = 200 << FRAC;
    localparam logic [OP_W-1:0] OP_SPARE_6   = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7   = 3'd7;
    localparam int              CLK_HALF     = 6;
    localparam int              DRAIN_CYCLES = 120;
    localparam int              CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [WORD_W-1:0] cpu_time;
        logic [PRIO_W-1:0] prio;
        logic [WORD_W-1:0] load_level;
        logic [WORD_W-1:0] scaled;
    } t_sched_result;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    // tdata, low bit up: ready_count, current_is_idle, recent_cpu_in, nice_value, zero fill
    logic [S_DATA_W-1:0]   s_axis_tdata   = '0;
    // tuser: op
    logic [OP_W-1:0]       s_axis_tuser   = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    // tdata, low bit up: recent_cpu_out, priority_out, load_average_out, scaled_report,
    // zero fill
    logic [M_DATA_W-1:0]   m_axis_tdata;

    int                    error_count    = 0;
    int                    cycle_count    = 0;
    int                    src_idle_pct   = 0;
    int                    sink_stall_pct = 0;
    longint                model_load     = 0;  // predicted load average, reset value
    t_sched_result         expected_results[$];
    t_sched_result         last_prediction;

    mlfq_priority_calculator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Keep the low 32 bits and sign-extend them again.
    function automatic longint wrap32(input longint v);
        logic signed [WORD_W-1:0] w;
        w = v[WORD_W-1:0];
        return longint'(w);
    endfunction

    // Round to nearest, halves away from zero.
    function automatic longint round_fx(input longint x);
        if (x >= 0)
            return (x + FP_ONE / 2) / FP_ONE;
        return (x - FP_ONE / 2) / FP_ONE;
    endfunction

    function automatic t_sched_result predict_result(
        input logic [OP_W-1:0]           op,
        input logic [READY_W-1:0]        ready,
        input logic                      idle,
        input logic signed [WORD_W-1:0]  rc_in,
        input logic signed [NICE_W-1:0]  nice_in
    );
        t_sched_result r;
        longint        rc;
        longint        nice;
        longint        rc_out;
        longint        prio;
        longint        report;
        longint        total;
        longint        d2;
        longint        den;
        longint        decay;
        longint        p;
        rc     = longint'(rc_in);
        nice   = longint'(nice_in);
        rc_out = rc;
        prio   = 0;
        report = 0;
        case (op)
            OP_LOAD_UPDATE: begin
                // The running thread counts unless it is the idle thread.
                total = longint'(ready);
                if (!idle)
                    total = total + 1;
                model_load = wrap32((LOAD_KEEP * model_load) / FP_ONE + LOAD_GAIN * total);
            end
            OP_DECAY: begin
                if (!idle) begin
                    d2    = wrap32(model_load * 2);
                    den   = wrap32(d2 + FP_ONE);
                    decay = 0;
                    if (den != 0)
                        decay = wrap32((d2 * FP_ONE) / den);
                    rc_out = wrap32((decay * rc) / FP_ONE + nice * FP_ONE);
                end
            end
            OP_PRIORITY: begin
                if (!idle) begin
                    p = longint'(PRIORITY_MAX) * FP_ONE - rc / 4 - nice * 2 * FP_ONE;
                    p = round_fx(p);
                    if (p < 0)
                        p = 0;
                    if (p > longint'(PRIORITY_MAX))
                        p = longint'(PRIORITY_MAX);
                    prio = p;
                end
            end
            OP_INCREMENT: begin
                if (!idle)
                    rc_out = wrap32(rc + FP_ONE);
            end
            OP_READ_LOAD: report = wrap32(round_fx(model_load * 100));
            OP_READ_CPU:  report = wrap32(round_fx(rc * 100));
            default: ;
        endcase
        r.cpu_time   = rc_out[WORD_W-1:0];
        r.prio       = prio[PRIO_W-1:0];
        r.load_level = model_load[WORD_W-1:0];
        r.scaled     = report[WORD_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short hold-offs, now and then one that spans a whole decay.
    function automatic int pick_hold_off();
        if ($urandom_range(7) == 0)
            return $urandom_range(60, 8);
        return $urandom_range(4, 1);
    endfunction

    function automatic logic [WORD_W-1:0] rand_thread_cpu();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(CPU_SPAN) - CPU_SPAN / 2;
            2: return $urandom_range(1023) - 512;
            default: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    // Mostly legal nice values, sometimes the whole 6-bit range.
    function automatic logic [NICE_W-1:0] rand_nice();
        if ($urandom_range(4) == 0)
            return NICE_W'($urandom_range(63));
        return NICE_W'($urandom_range(40) - 20);
    endfunction

    // Send one transaction and record its prediction once it is accepted.
    // Valid stays high after acceptance so back-to-back items need no extra edge.
    task automatic send_item(
        input logic [OP_W-1:0]    op,
        input logic [READY_W-1:0] ready,
        input logic               idle,
        input logic [WORD_W-1:0]  rc,
        input logic [NICE_W-1:0]  nice
    );
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat (pick_hold_off()) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, nice, rc, idle, ready};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        last_prediction = predict_result(op, ready, idle, rc, nice);
        expected_results.push_back(last_prediction);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // Stall the result side on a random share of the cycles.
    always @(posedge i_clk) begin
        m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("MISMATCH cycle %0d: %s got %h want %h", cycle_count, field, got, want);
        error_count++;
    endtask

    // Compare every result transaction against the oldest prediction.
    always @(posedge i_clk) begin : check_output
        t_sched_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[31:0] !== want.cpu_time)
                    report_mismatch("recent_cpu_out", m_axis_tdata[31:0], want.cpu_time);
                if (m_axis_tdata[37:32] !== want.prio)
                    report_mismatch("priority_out", WORD_W'(m_axis_tdata[37:32]),
                                    WORD_W'(want.prio));
                if (m_axis_tdata[69:38] !== want.load_level)
                    report_mismatch("load_average_out", m_axis_tdata[69:38],
                                    want.load_level);
                if (m_axis_tdata[101:70] !== want.scaled)
                    report_mismatch("scaled_report", m_axis_tdata[101:70], want.scaled);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hit field extremes, every opcode and the idle-thread cases back to back.
    // A zero decay divisor needs a load average of minus one half or just
    // below 2^17, which no ready count can reach, so it stays out of reach.
    task automatic test_corner_items();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_item(OP_READ_LOAD,   7'd0,   1'b0, 32'h0000_0000, '0);
        send_item(OP_READ_CPU,    7'd0,   1'b0, 32'h7FFF_FFFF, '0);
        send_item(OP_READ_CPU,    7'd0,   1'b0, 32'h8000_0000, '0);
        send_item(OP_READ_CPU,    7'd0,   1'b0, 32'd82,        '0);  // rounds up
        send_item(OP_READ_CPU,    7'd0,   1'b0, -32'sd82,      '0);  // rounds down
        send_item(OP_INCREMENT,   7'd0,   1'b0, 32'h7FFF_FFFF, '0);  // wraps
        send_item(OP_INCREMENT,   7'd0,   1'b1, 32'd1234,      '0);  // idle passes through
        send_item(OP_INCREMENT,   7'd0,   1'b0, 32'h8000_0000, '0);
        send_item(OP_PRIORITY,    7'd0,   1'b0, 32'h0000_0000, '0);
        send_item(OP_PRIORITY,    7'd0,   1'b0, 32'h0000_0000, NICE_W'(-20));  // clamp high
        send_item(OP_PRIORITY,    7'd0,   1'b0, 32'h0000_0000, NICE_W'(20));
        send_item(OP_PRIORITY,    7'd0,   1'b0, 32'h7FFF_FFFF, NICE_W'(20));   // clamp low
        send_item(OP_PRIORITY,    7'd0,   1'b0, 32'h8000_0000, NICE_W'(-32));
        send_item(OP_PRIORITY,    7'd0,   1'b0, 32'h0000_0000, NICE_W'(31));
        send_item(OP_PRIORITY,    7'd0,   1'b1, 32'h0000_0000, NICE_W'(-20));  // idle thread
        send_item(OP_DECAY,       7'd0,   1'b0, 32'h7FFF_FFFF, NICE_W'(-32));  // zero load
        send_item(OP_DECAY,       7'd0,   1'b1, 32'h1234_5678, NICE_W'(5));    // idle
        send_item(OP_LOAD_UPDATE, 7'd0,   1'b1, 32'h0000_0000, '0);            // nothing ready
        send_item(OP_LOAD_UPDATE, 7'd127, 1'b0, 32'hFFFF_FFFF, NICE_W'(31));
        send_item(OP_LOAD_UPDATE, 7'd64,  1'b0, 32'h0000_0000, '0);
        send_item(OP_DECAY,       7'd0,   1'b0, 32'h7FFF_FFFF, NICE_W'(31));
        send_item(OP_DECAY,       7'd0,   1'b0, 32'h8000_0000, NICE_W'(-20));
        send_item(OP_READ_LOAD,   7'd0,   1'b0, 32'h0000_0000, '0);
        send_item(OP_SPARE_6,     7'd127, 1'b0, 32'hDEAD_BEEF, NICE_W'(-1));
        send_item(OP_SPARE_7,     7'd1,   1'b1, 32'h8000_0000, NICE_W'(31));
    endtask

    // Drive the load average up with a full ready queue, then let it drain,
    // while one thread's recent CPU is carried from result to result.
    task automatic test_load_ramp();
        logic [WORD_W-1:0] thread_cpu;
        logic [NICE_W-1:0] thread_nice;
        thread_cpu  = '0;
        thread_nice = rand_nice();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < 250; i++) begin
            case (i % 5)
                0, 1, 2: begin
                    if (i < 150)
                        send_item(OP_LOAD_UPDATE, 7'd127, 1'b0, '0, '0);
                    else
                        send_item(OP_LOAD_UPDATE, 7'd0, 1'($urandom_range(1)), '0, '0);
                end
                3: begin
                    send_item(OP_INCREMENT, 7'd0, 1'b0, thread_cpu, thread_nice);
                    thread_cpu = last_prediction.cpu_time;
                end
                default: begin
                    case ((i / 5) % 4)
                        0: begin
                            send_item(OP_DECAY, 7'd0, 1'b0, thread_cpu, thread_nice);
                            thread_cpu = last_prediction.cpu_time;
                        end
                        1: send_item(OP_PRIORITY,  7'd0, 1'b0, thread_cpu, thread_nice);
                        2: send_item(OP_READ_LOAD, 7'd0, 1'b0, thread_cpu, thread_nice);
                        default: send_item(OP_READ_CPU, 7'd0, 1'b0, thread_cpu, thread_nice);
                    endcase
                end
            endcase
        end
    endtask

    // Random opcode mix; the ready count follows a target that moves now and
    // then so the load average wanders over its whole reachable range.
    task automatic test_random_ops(input int count, input int src_pct, input int sink_pct);
        logic [OP_W-1:0]    op;
        logic [READY_W-1:0] ready_target;
        logic [READY_W-1:0] ready;
        int                 pick;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        ready_target   = READY_W'($urandom_range(127));
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 63)
                ready_target = READY_W'($urandom_range(127));
            pick = $urandom_range(99);
            if (pick < 30)
                op = OP_LOAD_UPDATE;
            else if (pick < 55)
                op = OP_DECAY;
            else if (pick < 70)
                op = OP_PRIORITY;
            else if (pick < 80)
                op = OP_INCREMENT;
            else if (pick < 88)
                op = OP_READ_LOAD;
            else if (pick < 96)
                op = OP_READ_CPU;
            else
                op = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
            ready = ($urandom_range(3) == 0) ? READY_W'($urandom_range(127)) : ready_target;
            send_item(op, ready, $urandom_range(6) == 0, rand_thread_cpu(), rand_nice());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_items();
        test_load_ramp();
        test_random_ops(200, 0, 0);
        test_random_ops(200, 50, 0);
        test_random_ops(200, 0, 50);
        test_random_ops(200, 25, 25);

        // Drop valid, wait for every result, then watch for strays.
        s_axis_tvalid  <= 1'b0;
        sink_stall_pct  = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
